// ===== hw/rtl/mau_pkg.sv =====
// shared types, constants and saturation helpers for the multi-turn angle unwrap
package mau_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_ZONE   = 2'd2;
    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic signed [15:0] LOWER_LIMIT_RST = 16'sd0;
    localparam logic signed [15:0] UPPER_LIMIT_RST = 16'sd8192;
    localparam logic [14:0]        WRAP_ZONE_RST   = 15'd2048;

    // previous raw angle after reset: half the reset range
    localparam logic signed [15:0] PREV_RAW_RST = 16'sd4096;

    // item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_SYNC   = 1'b1;

    // stream widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 80;

    typedef struct packed {
        logic signed [15:0] lower_limit;
        logic signed [15:0] upper_limit;
        logic [14:0]        wrap_zone;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] raw_angle;
        logic signed [31:0] setpoint;
    } item_t;

    typedef struct packed {
        logic signed [15:0] turn_count;
        logic signed [31:0] adjusted_setpoint;
        logic signed [31:0] extended_angle;
    } result_t;

    // clamp a 34-bit two's complement value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = {1'b1, {31{1'b0}}};
        end else begin
            r = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

    // clamp a 17-bit two's complement value to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v[16] == v[15]) begin
            r = v[15:0];
        end else if (v[16]) begin
            r = {1'b1, {15{1'b0}}};
        end else begin
            r = {1'b0, {15{1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/mau_cfg.sv =====
// configuration registers: limits and wrap zone width
module mau_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mau_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mau_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output mau_pkg::cfg_t                     cfg
);

    mau_pkg::cfg_t cfg_reg;
    mau_pkg::cfg_t cfg_next;

    // decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                mau_pkg::CFG_LOWER_LIMIT: cfg_next.lower_limit = cfg_wdata;
                mau_pkg::CFG_UPPER_LIMIT: cfg_next.upper_limit = cfg_wdata;
                mau_pkg::CFG_WRAP_ZONE:   cfg_next.wrap_zone   = cfg_wdata[14:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lower_limit <= mau_pkg::LOWER_LIMIT_RST;
            cfg_reg.upper_limit <= mau_pkg::UPPER_LIMIT_RST;
            cfg_reg.wrap_zone   <= mau_pkg::WRAP_ZONE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/mau_core.sv =====
// tracking state and the single-pass unwrap and synchronise datapath
module mau_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mau_pkg::cfg_t        cfg,
    input  mau_pkg::item_t       item,
    input  logic                 step,
    output mau_pkg::result_t     res,
    output logic signed [15:0]   turns
);

    logic signed [15:0] prev_raw_reg, prev_raw_next;
    logic signed [15:0] turns_reg, turns_next;
    logic signed [31:0] fb_reg, fb_next;

    // limits and edges, widened so nothing overflows
    logic signed [16:0] range_s;
    logic signed [17:0] hi_edge;
    logic signed [17:0] lo_edge;
    logic signed [17:0] raw_w;
    logic signed [17:0] prev_w;
    logic signed [31:0] upper_w;
    logic signed [31:0] lower_w;

    assign range_s = {cfg.upper_limit[15], cfg.upper_limit}
                   - {cfg.lower_limit[15], cfg.lower_limit};
    assign hi_edge = {{2{cfg.upper_limit[15]}}, cfg.upper_limit} - {3'b000, cfg.wrap_zone};
    assign lo_edge = {{2{cfg.lower_limit[15]}}, cfg.lower_limit} + {3'b000, cfg.wrap_zone};
    assign raw_w   = {{2{item.raw_angle[15]}}, item.raw_angle};
    assign prev_w  = {{2{prev_raw_reg[15]}}, prev_raw_reg};
    assign upper_w = {{16{cfg.upper_limit[15]}}, cfg.upper_limit};
    assign lower_w = {{16{cfg.lower_limit[15]}}, cfg.lower_limit};

    // wrap detection on a sample
    logic               wrap_dec;
    logic               wrap_inc;
    logic signed [15:0] turns_dec;
    logic signed [15:0] turns_inc;
    logic signed [15:0] turns_smp;

    assign wrap_dec  = (raw_w >= hi_edge) && (prev_w < lo_edge);
    assign wrap_inc  = (raw_w < lo_edge) && (prev_w >= hi_edge);
    assign turns_dec = mau_pkg::sat16({turns_reg[15], turns_reg} - 17'sd1);
    assign turns_inc = mau_pkg::sat16({turns_reg[15], turns_reg} + 17'sd1);
    assign turns_smp = wrap_dec ? turns_dec : (wrap_inc ? turns_inc : turns_reg);

    // extended angle: raw plus range times turns
    logic signed [32:0] prod;
    logic signed [33:0] smp_sum;

    assign prod    = range_s * turns_smp;
    assign smp_sum = {prod[32], prod} + {{18{item.raw_angle[15]}}, item.raw_angle};

    // synchronise shift by one range
    logic               sync_down;
    logic               sync_up;
    logic signed [33:0] range_w;
    logic signed [33:0] fb_w;
    logic signed [33:0] sp_w;
    logic signed [31:0] fb_dn, fb_up, sp_dn, sp_up;

    assign sync_down = (fb_reg >= upper_w) && (item.setpoint >= upper_w);
    assign sync_up   = (fb_reg < lower_w) && (item.setpoint < lower_w);
    assign range_w   = {{17{range_s[16]}}, range_s};
    assign fb_w      = {{2{fb_reg[31]}}, fb_reg};
    assign sp_w      = {{2{item.setpoint[31]}}, item.setpoint};
    assign fb_dn     = mau_pkg::sat32(fb_w - range_w);
    assign fb_up     = mau_pkg::sat32(fb_w + range_w);
    assign sp_dn     = mau_pkg::sat32(sp_w - range_w);
    assign sp_up     = mau_pkg::sat32(sp_w + range_w);

    // next state and result for the current item
    always_comb begin
        prev_raw_next         = prev_raw_reg;
        turns_next            = turns_reg;
        fb_next               = fb_reg;
        res.adjusted_setpoint = item.setpoint;
        case (item.kind)
            mau_pkg::KIND_SAMPLE: begin
                prev_raw_next = item.raw_angle;
                turns_next    = turns_smp;
                fb_next       = mau_pkg::sat32(smp_sum);
            end
            mau_pkg::KIND_SYNC: begin
                if (sync_down) begin
                    fb_next               = fb_dn;
                    res.adjusted_setpoint = sp_dn;
                    turns_next            = turns_dec;
                end else if (sync_up) begin
                    fb_next               = fb_up;
                    res.adjusted_setpoint = sp_up;
                    turns_next            = turns_inc;
                end
            end
            default: begin
                turns_next = turns_reg;
            end
        endcase
        res.extended_angle = fb_next;
        res.turn_count     = turns_next;
    end

    // state advances once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_raw_reg <= mau_pkg::PREV_RAW_RST;
            turns_reg    <= '0;
            fb_reg       <= '0;
        end else if (step) begin
            prev_raw_reg <= prev_raw_next;
            turns_reg    <= turns_next;
            fb_reg       <= fb_next;
        end
    end

    assign turns = turns_reg;

endmodule

// ===== hw/rtl/multiturn_angle_unwrap.sv =====
// The edge that accepts the input transaction loads the input register; the result
// register is loaded when the item moves on. Throughput: one item per cycle while
// m_tready is high; the angle state updates as an item moves into the result register,
// so each item sees the state left by the one before it.
// Reset (aresetn low, synchronous): limits 0/8192, wrap zone 2048, turns and feedback 0,
// previous raw angle 4096, both pipeline registers empty.
module multiturn_angle_unwrap (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mau_pkg::S_TDATA_W-1:0]     s_tdata,  // raw_angle[15:0], setpoint[47:16]
    input  logic                              s_tuser,  // kind[0]
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mau_pkg::M_TDATA_W-1:0]     m_tdata,  // extended_angle[31:0],
                                                        // adjusted_setpoint[63:32],
                                                        // turn_count[79:64]
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [mau_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mau_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    mau_pkg::cfg_t    cfg;
    mau_pkg::item_t   in_item_reg, in_item_next;
    logic             in_valid_reg, in_valid_next;
    mau_pkg::result_t res;
    mau_pkg::result_t res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    logic signed [15:0] turns_cur;
    logic             advance;
    logic             in_take;

    mau_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mau_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (in_item_reg),
        .step    (advance),
        .res     (res),
        .turns   (turns_cur)
    );

    // handshake: item moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // next values of the two pipeline registers
    always_comb begin
        in_item_next  = in_item_reg;
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_item_next.kind      = s_tuser;
            in_item_next.raw_angle = s_tdata[15:0];
            in_item_next.setpoint  = s_tdata[47:16];
            in_valid_next          = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            res_next       = res;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        res_reg     <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.turn_count, res_reg.adjusted_setpoint, res_reg.extended_angle};

`ifndef SYNTHESIS
    // back-pressure only while an item sits in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // a sample passes the setpoint through untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.kind == mau_pkg::KIND_SAMPLE)
        |=> (res_reg.adjusted_setpoint == $past(in_item_reg.setpoint)))
        else $error("sample altered the setpoint");

    // the turn count moves by at most one per item
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> ((res_reg.turn_count == $past(turns_cur))
                  || (res_reg.turn_count == $past(turns_cur) + 16'sd1)
                  || (res_reg.turn_count == $past(turns_cur) - 16'sd1)))
        else $error("turn count jumped by more than one");

    // a result reaches the output only from an item that moved on
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(advance))
        else $error("result appeared without an item");
`endif

endmodule
